// ----- hw/rtl/lfp_pkg.sv -----
// Shared types and constants for the lidar frame parser.
// No dependencies; every other file in hw/rtl uses this package.
`timescale 1ns / 1ps

package lfp_pkg;

  // Frame layout.
  localparam logic [7:0] HDR_BYTE  = 8'h59;
  localparam int unsigned FRAME_LEN = 9;
  localparam int unsigned POS_W     = 4;

  // Configuration register file.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET     = 3'd0,
    CFG_MIN_DIST   = 3'd1,
    CFG_MAX_DIST   = 3'd2,
    CFG_MIN_STR    = 3'd3,
    CFG_STALE_LIM  = 3'd4
  } cfg_idx_e;

  localparam logic [9:0]  RST_OFFSET_CM    = 10'd0;
  localparam logic [15:0] RST_MIN_DIST_CM  = 16'd20;
  localparam logic [15:0] RST_MAX_DIST_CM  = 16'd800;
  localparam logic [15:0] RST_MIN_STRENGTH = 16'd100;
  localparam logic [15:0] RST_STALE_LIM_MS = 16'd2000;

  typedef struct packed {
    logic [9:0]  offset_cm;
    logic [15:0] min_distance_cm;
    logic [15:0] max_distance_cm;
    logic [15:0] min_strength;
    logic [15:0] stale_limit_ms;
  } cfg_t;

  // Item kinds.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  // Per-frame outcome reported with every result.
  typedef enum logic [1:0] {
    STS_NONE     = 2'd0,
    STS_ACCEPT   = 2'd1,
    STS_CSUM_ERR = 2'd2,
    STS_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] range_cm;
    logic [15:0] strength;
    logic        reading_valid;
    status_e     frame_status;
  } result_t;

endpackage

// ----- hw/rtl/lfp_intf.sv -----
// Valid/ready channel interfaces for the lidar frame parser ports.
// Depends on lfp_pkg for field widths.
`timescale 1ns / 1ps

// Input channel: one received byte or one millisecond tick per beat.
interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// Output channel: one result per input beat.
interface lfp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_cm;
  logic [15:0] strength;
  logic        reading_valid;
  logic [1:0]  frame_status;

  modport source (output valid, output range_cm, output strength,
                  output reading_valid, output frame_status, input ready);
  modport sink   (input valid, input range_cm, input strength,
                  input reading_valid, input frame_status, output ready);
endinterface

// Configuration write channel.
interface lfp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lfp_pkg::CFG_IDX_W-1:0]    index;
  logic [lfp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/lfp_cfg_regs.sv -----
// Configuration register file of the lidar frame parser.
// Depends on lfp_pkg and the lfp_cfg_if interface.
`timescale 1ns / 1ps

module lfp_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  lfp_cfg_if.sink        cfg_i,
  output lfp_pkg::cfg_t  cfg_o
);

  lfp_pkg::cfg_t cfg_q;
  lfp_pkg::cfg_t cfg_d;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        lfp_pkg::CFG_OFFSET:    cfg_d.offset_cm       = cfg_i.data[9:0];
        lfp_pkg::CFG_MIN_DIST:  cfg_d.min_distance_cm = cfg_i.data;
        lfp_pkg::CFG_MAX_DIST:  cfg_d.max_distance_cm = cfg_i.data;
        lfp_pkg::CFG_MIN_STR:   cfg_d.min_strength    = cfg_i.data;
        lfp_pkg::CFG_STALE_LIM: cfg_d.stale_limit_ms  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_cm       <= lfp_pkg::RST_OFFSET_CM;
      cfg_q.min_distance_cm <= lfp_pkg::RST_MIN_DIST_CM;
      cfg_q.max_distance_cm <= lfp_pkg::RST_MAX_DIST_CM;
      cfg_q.min_strength    <= lfp_pkg::RST_MIN_STRENGTH;
      cfg_q.stale_limit_ms  <= lfp_pkg::RST_STALE_LIM_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/lfp_parser.sv -----
// Frame parser state and its combinational next-state update for one registered item.
// Depends on lfp_pkg.
`timescale 1ns / 1ps

module lfp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  lfp_pkg::item_t    item_i,
  input  lfp_pkg::cfg_t     cfg_i,
  output lfp_pkg::result_t  result_o
);

  localparam int unsigned PW = lfp_pkg::POS_W;

  // Byte positions within a frame.
  localparam logic [PW-1:0] POS_HUNT   = PW'(0);
  localparam logic [PW-1:0] POS_HDR2   = PW'(1);
  localparam logic [PW-1:0] POS_DIST_L = PW'(2);
  localparam logic [PW-1:0] POS_DIST_H = PW'(3);
  localparam logic [PW-1:0] POS_STR_L  = PW'(4);
  localparam logic [PW-1:0] POS_STR_H  = PW'(5);
  localparam logic [PW-1:0] POS_LAST_D = PW'(lfp_pkg::FRAME_LEN - 2);

  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    sum_q, sum_d;
  logic [15:0]   raw_dist_q, raw_dist_d;
  logic [15:0]   raw_str_q, raw_str_d;
  logic [15:0]   kept_dist_q, kept_dist_d;
  logic [15:0]   kept_str_q, kept_str_d;
  logic          valid_q, valid_d;
  logic [15:0]   elapsed_q, elapsed_d;
  lfp_pkg::status_e status;

  logic [15:0] offset_ext;
  logic [15:0] adj_dist;
  logic [7:0]  b;
  logic        in_range;

  assign b          = item_i.rx_byte;
  assign offset_ext = {6'd0, cfg_i.offset_cm};

  // Offset removal with a floor at zero, then the acceptance window.
  assign adj_dist = (raw_dist_q > offset_ext) ? (raw_dist_q - offset_ext) : 16'd0;
  assign in_range = (adj_dist >= cfg_i.min_distance_cm) &&
                    (adj_dist <= cfg_i.max_distance_cm) &&
                    (raw_str_q > cfg_i.min_strength);

  // Next-state logic for one item.
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    raw_dist_d  = raw_dist_q;
    raw_str_d   = raw_str_q;
    kept_dist_d = kept_dist_q;
    kept_str_d  = kept_str_q;
    valid_d     = valid_q;
    elapsed_d   = elapsed_q;
    status      = lfp_pkg::STS_NONE;

    if (item_i.opcode == lfp_pkg::OP_TICK) begin
      // Saturating age counter; staleness is tested after the increment.
      if (elapsed_q != 16'hFFFF) begin
        elapsed_d = elapsed_q + 16'd1;
      end
      if (elapsed_d > cfg_i.stale_limit_ms) begin
        valid_d = 1'b0;
      end
    end else begin
      case (pos_q) inside
        POS_HUNT: begin
          if (b == lfp_pkg::HDR_BYTE) begin
            sum_d = b;
            pos_d = POS_HDR2;
          end
        end
        POS_HDR2: begin
          // A false start drops this byte and goes back to hunting.
          if (b == lfp_pkg::HDR_BYTE) begin
            sum_d = sum_q + b;
            pos_d = POS_DIST_L;
          end else begin
            pos_d = POS_HUNT;
          end
        end
        [POS_DIST_L:POS_LAST_D]: begin
          sum_d = sum_q + b;
          pos_d = pos_q + PW'(1);
          case (pos_q)
            POS_DIST_L: raw_dist_d[7:0]  = b;
            POS_DIST_H: raw_dist_d[15:8] = b;
            POS_STR_L:  raw_str_d[7:0]   = b;
            POS_STR_H:  raw_str_d[15:8]  = b;
            default: ;
          endcase
        end
        default: begin
          // Checksum byte closes the frame.
          pos_d = POS_HUNT;
          if (b != sum_q) begin
            status = lfp_pkg::STS_CSUM_ERR;
          end else if (in_range) begin
            kept_dist_d = adj_dist;
            kept_str_d  = raw_str_q;
            valid_d     = 1'b1;
            elapsed_d   = 16'd0;
            status      = lfp_pkg::STS_ACCEPT;
          end else begin
            status = lfp_pkg::STS_RANGE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HUNT;
      sum_q       <= 8'd0;
      raw_dist_q  <= 16'd0;
      raw_str_q   <= 16'd0;
      kept_dist_q <= 16'd0;
      kept_str_q  <= 16'd0;
      valid_q     <= 1'b0;
      elapsed_q   <= 16'd0;
    end else if (adv_i) begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      raw_dist_q  <= raw_dist_d;
      raw_str_q   <= raw_str_d;
      kept_dist_q <= kept_dist_d;
      kept_str_q  <= kept_str_d;
      valid_q     <= valid_d;
      elapsed_q   <= elapsed_d;
    end
  end

  // Result reflects the state after this item.
  assign result_o.range_cm      = kept_dist_d;
  assign result_o.strength      = kept_str_d;
  assign result_o.reading_valid = valid_d;
  assign result_o.frame_status  = status;

endmodule

// ----- hw/rtl/lidar_frame_parser.sv -----
// Top level of the lidar frame parser: input register, parser, result register.
// Depends on lfp_pkg, lfp_intf, lfp_cfg_regs and lfp_parser.
//
//   port    dir  beat contents
//   in_i    in   opcode (byte / ms tick), rx_byte
//   out_o   out  range_cm, strength, reading_valid, frame_status
//   cfg_i   in   index, data (register write)
//
// One beat in, one beat out; a new beat is taken every cycle while in_i.ready is high.
// The input register feeds the parser update, which is registered into the result register.
// Reset is asynchronous and active low; it clears the parser state and loads register defaults.
// A stalled output holds the result register; the input register fills behind it,
// and in_i.ready drops only when both are full.
`timescale 1ns / 1ps

module lidar_frame_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfp_in_if.sink    in_i,
  lfp_out_if.source out_o,
  lfp_cfg_if.sink   cfg_i
);

  lfp_pkg::cfg_t    cfg;
  lfp_pkg::item_t   s1_item_q;
  logic             s1_valid_q;
  lfp_pkg::result_t res_next;
  lfp_pkg::result_t res_q;
  logic             out_valid_q;
  logic             s2_ready;
  logic             s1_adv;
  logic             in_ready;

  lfp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Pipeline flow control.
  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q.opcode  <= lfp_pkg::opcode_e'(in_i.opcode);
      s1_item_q.rx_byte <= in_i.rx_byte;
    end
  end

  lfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (res_next)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_next;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.range_cm      = res_q.range_cm;
  assign out_o.strength      = res_q.strength;
  assign out_o.reading_valid = res_q.reading_valid;
  assign out_o.frame_status  = res_q.frame_status;

  // An accepted frame always reports a live reading.
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.frame_status == lfp_pkg::STS_ACCEPT) |-> res_q.reading_valid)
    else $error("accepted frame without reading_valid");

  // A held input beat keeps its contents while the result side is stalled.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_item_q))
    else $error("input register changed while stalled");

  // With an empty result register the block always takes input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
